FILE: hdl/fsmb_pkg.sv
package fsmb_pkg;

  localparam int IdW     = 8;
  localparam int ValW    = 32;
  localparam int KindW   = 3;
  localparam int ModeW   = 2;
  localparam int ElemsW  = 5;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 5;

  localparam logic [ModeW-1:0] MODE_EXCL   = 2'd0;
  localparam logic [ModeW-1:0] MODE_SHARED = 2'd1;
  localparam logic [ModeW-1:0] MODE_QUEUE  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_MODE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RING_ELEMS = 1'd1;

  localparam logic [ElemsW-1:0] RING_ELEMS_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_SERVED  = 3'd0,
    KIND_SETDONE = 3'd1,
    KIND_BLOCKED = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_GWOKEN  = 3'd4,
    KIND_SWOKEN  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_WAITING = 2'd1,
    SLOT_READY   = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIM,
    ST_XWAKE,
    ST_BCAST,
    ST_BWAIT,
    ST_RWAIT,
    ST_GWAKE,
    ST_ADMIT
  } state_e;

  typedef enum logic [2:0] {
    PLAN_NONE,
    PLAN_XWAKE,
    PLAN_BCAST,
    PLAN_GWAKE,
    PLAN_ADMIT
  } plan_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_PRIM,
    OP_XWAKE,
    OP_BCAST,
    OP_GWAKE,
    OP_ADMIT
  } dp_op_e;

  typedef struct packed {
    plan_e plan;
    logic  bcast_more;
    logic  admit_ok;
  } dp_status_t;

  typedef struct packed {
    logic            cmd;
    logic [IdW-1:0]  caller_id;
    logic [ValW-1:0] set_value;
  } in_word_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   target_id;
    logic [ValW-1:0]  out_value;
    logic             last;
  } out_word_t;

endpackage

FILE: hdl/fsmb_ctrl.sv
module fsmb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  fsmb_pkg::dp_status_t status_i,
  output fsmb_pkg::dp_op_e     op_o,
  output logic                 busy_o
);

  fsmb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsmb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = fsmb_pkg::OP_NONE;
    busy_o  = 1'b1;
    case (state_q)
      fsmb_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          op_o    = fsmb_pkg::OP_LATCH;
          state_d = fsmb_pkg::ST_PRIM;
        end
      end
      fsmb_pkg::ST_PRIM: begin
        op_o = fsmb_pkg::OP_PRIM;
        case (status_i.plan)
          fsmb_pkg::PLAN_XWAKE: state_d = fsmb_pkg::ST_XWAKE;
          fsmb_pkg::PLAN_BCAST: state_d = fsmb_pkg::ST_BCAST;
          fsmb_pkg::PLAN_GWAKE: state_d = fsmb_pkg::ST_RWAIT;
          fsmb_pkg::PLAN_ADMIT: state_d = fsmb_pkg::ST_ADMIT;
          default:              state_d = fsmb_pkg::ST_IDLE;
        endcase
      end
      fsmb_pkg::ST_XWAKE: begin
        op_o    = fsmb_pkg::OP_XWAKE;
        state_d = fsmb_pkg::ST_IDLE;
      end
      fsmb_pkg::ST_BCAST: begin
        op_o    = fsmb_pkg::OP_BCAST;
        state_d = status_i.bcast_more ? fsmb_pkg::ST_BWAIT : fsmb_pkg::ST_IDLE;
      end
      fsmb_pkg::ST_BWAIT: state_d = fsmb_pkg::ST_BCAST;
      fsmb_pkg::ST_RWAIT: state_d = fsmb_pkg::ST_GWAKE;
      fsmb_pkg::ST_GWAKE: begin
        op_o    = fsmb_pkg::OP_GWAKE;
        state_d = status_i.admit_ok ? fsmb_pkg::ST_ADMIT : fsmb_pkg::ST_IDLE;
      end
      fsmb_pkg::ST_ADMIT: begin
        op_o    = fsmb_pkg::OP_ADMIT;
        state_d = fsmb_pkg::ST_IDLE;
      end
      default: state_d = fsmb_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/fsmb_dpath.sv
module fsmb_dpath #(
  parameter int RING_DEPTH = 16,
  parameter int WAIT_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fsmb_pkg::dp_op_e              op_i,
  input  fsmb_pkg::in_word_t            in_i,
  input  logic                          cfg_we_i,
  input  logic [fsmb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fsmb_pkg::CfgW-1:0]     cfg_data_i,
  output fsmb_pkg::dp_status_t          status_o,
  output logic                          result_valid_o,
  output fsmb_pkg::out_word_t           result_o
);

  localparam int RP = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int NW = $clog2(RING_DEPTH + 1);
  localparam int WP = $clog2(WAIT_DEPTH);
  localparam int WL = $clog2(WAIT_DEPTH + 1);
  localparam int IW = fsmb_pkg::IdW;
  localparam int VW = fsmb_pkg::ValW;

  logic [fsmb_pkg::ModeW-1:0]  mode_q;
  logic [fsmb_pkg::ElemsW-1:0] elems_q;
  fsmb_pkg::slot_e             slot_q, slot_d;
  logic [IW-1:0]               waiter_q, waiter_d;
  logic [VW-1:0]               held_q, held_d;
  logic [RP-1:0]               head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]               count_q, count_d;
  logic [WP-1:0]               g_rd_q, g_rd_d, g_wr_q, g_wr_d;
  logic [WL-1:0]               g_len_q, g_len_d;
  logic [WP-1:0]               s_rd_q, s_rd_d, s_wr_q, s_wr_d;
  logic [WL-1:0]               s_len_q, s_len_d;
  fsmb_pkg::in_word_t          in_q, in_d;
  fsmb_pkg::out_word_t         res_q, res_d;
  logic                        valid_q, emit;

  logic [VW-1:0] ring_mem [RING_DEPTH];
  logic [IW-1:0] gq_mem [WAIT_DEPTH];
  logic [IW-1:0] sq_id_mem [WAIT_DEPTH];
  logic [VW-1:0] sq_val_mem [WAIT_DEPTH];
  logic [VW-1:0] ring_rd_q, ring_wd;
  logic [IW-1:0] gq_rd_q, sq_id_rd_q;
  logic [VW-1:0] sq_val_rd_q;
  logic          ring_we, gq_we, sq_we;

  logic [NW-1:0] ring_n;
  logic          g_full, s_full;

  fsmb_pkg::plan_e plan;
  logic            bcast_more, admit_ok;

  function automatic logic [RP-1:0] ring_next(input logic [RP-1:0] p, input logic [NW-1:0] n);
    logic [NW:0] inc;
    inc = (NW+1)'(p) + 1'b1;
    return (inc >= (NW+1)'(n)) ? '0 : inc[RP-1:0];
  endfunction

  function automatic logic [WP-1:0] wait_next(input logic [WP-1:0] p);
    return (p == WP'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    if (elems_q == '0) begin
      ring_n = NW'(1);
    end else if (int'(elems_q) > RING_DEPTH) begin
      ring_n = NW'(RING_DEPTH);
    end else begin
      ring_n = NW'(elems_q);
    end
  end

  assign g_full = (g_len_q == WL'(WAIT_DEPTH));
  assign s_full = (s_len_q == WL'(WAIT_DEPTH));

  assign bcast_more = (g_len_q > WL'(1));
  assign admit_ok   = (s_len_q != '0) && ((count_q - 1'b1) < ring_n);

  assign status_o = '{plan: plan, bcast_more: bcast_more, admit_ok: admit_ok};

  always_comb begin
    slot_d        = slot_q;
    waiter_d      = waiter_q;
    held_d        = held_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    g_rd_d        = g_rd_q;
    g_wr_d        = g_wr_q;
    g_len_d       = g_len_q;
    s_rd_d        = s_rd_q;
    s_wr_d        = s_wr_q;
    s_len_d       = s_len_q;
    in_d          = in_q;
    res_d         = res_q;
    emit          = 1'b0;
    ring_we       = 1'b0;
    ring_wd       = in_q.set_value;
    gq_we         = 1'b0;
    sq_we         = 1'b0;
    plan          = fsmb_pkg::PLAN_NONE;
    case (op_i)
      fsmb_pkg::OP_LATCH: in_d = in_i;
      fsmb_pkg::OP_PRIM: begin
        emit            = 1'b1;
        res_d.target_id = in_q.caller_id;
        res_d.out_value = '0;
        res_d.kind      = fsmb_pkg::KIND_ERROR;
        case (mode_q)
          fsmb_pkg::MODE_EXCL: begin
            if (in_q.cmd == fsmb_pkg::CMD_GET) begin
              case (slot_q)
                fsmb_pkg::SLOT_READY: begin
                  res_d.kind      = fsmb_pkg::KIND_SERVED;
                  res_d.out_value = held_q;
                  slot_d          = fsmb_pkg::SLOT_EMPTY;
                end
                fsmb_pkg::SLOT_EMPTY: begin
                  res_d.kind = fsmb_pkg::KIND_BLOCKED;
                  slot_d     = fsmb_pkg::SLOT_WAITING;
                  waiter_d   = in_q.caller_id;
                end
                default: res_d.kind = fsmb_pkg::KIND_ERROR;
              endcase
            end else begin
              case (slot_q)
                fsmb_pkg::SLOT_WAITING: begin
                  res_d.kind    = fsmb_pkg::KIND_SETDONE;
                  held_d        = in_q.set_value;
                  slot_d        = fsmb_pkg::SLOT_EMPTY;
                  plan          = fsmb_pkg::PLAN_XWAKE;
                end
                fsmb_pkg::SLOT_EMPTY: begin
                  res_d.kind = fsmb_pkg::KIND_SETDONE;
                  held_d     = in_q.set_value;
                  slot_d     = fsmb_pkg::SLOT_READY;
                end
                default: res_d.kind = fsmb_pkg::KIND_ERROR;
              endcase
            end
          end
          fsmb_pkg::MODE_SHARED: begin
            if (in_q.cmd == fsmb_pkg::CMD_GET) begin
              if (slot_q == fsmb_pkg::SLOT_READY) begin
                res_d.kind      = fsmb_pkg::KIND_SERVED;
                res_d.out_value = held_q;
              end else if (!g_full) begin
                res_d.kind = fsmb_pkg::KIND_BLOCKED;
                gq_we      = 1'b1;
                g_wr_d     = wait_next(g_wr_q);
                g_len_d    = g_len_q + 1'b1;
                slot_d     = fsmb_pkg::SLOT_WAITING;
              end
            end else if (slot_q != fsmb_pkg::SLOT_READY) begin
              res_d.kind = fsmb_pkg::KIND_SETDONE;
              held_d     = in_q.set_value;
              slot_d     = fsmb_pkg::SLOT_READY;
              if (slot_q == fsmb_pkg::SLOT_WAITING && g_len_q != '0) begin
                plan = fsmb_pkg::PLAN_BCAST;
              end
            end
          end
          fsmb_pkg::MODE_QUEUE: begin
            if (in_q.cmd == fsmb_pkg::CMD_GET) begin
              if (count_q == '0) begin
                if (!g_full) begin
                  res_d.kind = fsmb_pkg::KIND_BLOCKED;
                  gq_we      = 1'b1;
                  g_wr_d     = wait_next(g_wr_q);
                  g_len_d    = g_len_q + 1'b1;
                end
              end else begin
                res_d.kind      = fsmb_pkg::KIND_SERVED;
                res_d.out_value = ring_rd_q;
                head_d          = ring_next(head_q, ring_n);
                count_d         = count_q - 1'b1;
                if (admit_ok) begin
                  plan = fsmb_pkg::PLAN_ADMIT;
                end
              end
            end else if (count_q >= ring_n) begin
              if (!s_full) begin
                res_d.kind = fsmb_pkg::KIND_BLOCKED;
                sq_we      = 1'b1;
                s_wr_d     = wait_next(s_wr_q);
                s_len_d    = s_len_q + 1'b1;
              end
            end else begin
              res_d.kind = fsmb_pkg::KIND_SETDONE;
              ring_we    = 1'b1;
              tail_d     = ring_next(tail_q, ring_n);
              count_d    = count_q + 1'b1;
              if (g_len_q != '0) begin
                plan = fsmb_pkg::PLAN_GWAKE;
              end
            end
          end
          default: res_d.kind = fsmb_pkg::KIND_ERROR;
        endcase
        res_d.last = (plan == fsmb_pkg::PLAN_NONE);
      end
      fsmb_pkg::OP_XWAKE: begin
        emit            = 1'b1;
        res_d.kind      = fsmb_pkg::KIND_GWOKEN;
        res_d.target_id = waiter_q;
        res_d.out_value = held_q;
        res_d.last      = 1'b1;
      end
      fsmb_pkg::OP_BCAST: begin
        emit            = 1'b1;
        res_d.kind      = fsmb_pkg::KIND_GWOKEN;
        res_d.target_id = gq_rd_q;
        res_d.out_value = held_q;
        res_d.last      = !bcast_more;
        g_rd_d          = wait_next(g_rd_q);
        g_len_d         = g_len_q - 1'b1;
      end
      fsmb_pkg::OP_GWAKE: begin
        emit            = 1'b1;
        res_d.kind      = fsmb_pkg::KIND_GWOKEN;
        res_d.target_id = gq_rd_q;
        res_d.out_value = ring_rd_q;
        res_d.last      = !admit_ok;
        g_rd_d          = wait_next(g_rd_q);
        g_len_d         = g_len_q - 1'b1;
        head_d          = ring_next(head_q, ring_n);
        count_d         = count_q - 1'b1;
      end
      fsmb_pkg::OP_ADMIT: begin
        emit            = 1'b1;
        res_d.kind      = fsmb_pkg::KIND_SWOKEN;
        res_d.target_id = sq_id_rd_q;
        res_d.out_value = '0;
        res_d.last      = 1'b1;
        ring_we         = 1'b1;
        ring_wd         = sq_val_rd_q;
        tail_d          = ring_next(tail_q, ring_n);
        count_d         = count_q + 1'b1;
        s_rd_d          = wait_next(s_rd_q);
        s_len_d         = s_len_q - 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= fsmb_pkg::MODE_EXCL;
      elems_q  <= fsmb_pkg::RING_ELEMS_RESET;
      slot_q   <= fsmb_pkg::SLOT_EMPTY;
      waiter_q <= '0;
      held_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      g_rd_q   <= '0;
      g_wr_q   <= '0;
      g_len_q  <= '0;
      s_rd_q   <= '0;
      s_wr_q   <= '0;
      s_len_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == fsmb_pkg::CFG_SYNC_MODE) begin
        mode_q <= cfg_data_i[fsmb_pkg::ModeW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == fsmb_pkg::CFG_RING_ELEMS) begin
        elems_q <= cfg_data_i[fsmb_pkg::ElemsW-1:0];
      end
      slot_q   <= slot_d;
      waiter_q <= waiter_d;
      held_q   <= held_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      g_rd_q   <= g_rd_d;
      g_wr_q   <= g_wr_d;
      g_len_q  <= g_len_d;
      s_rd_q   <= s_rd_d;
      s_wr_q   <= s_wr_d;
      s_len_q  <= s_len_d;
      valid_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[tail_q] <= ring_wd;
    end
    ring_rd_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (gq_we) begin
      gq_mem[g_wr_q] <= in_q.caller_id;
    end
    gq_rd_q <= gq_mem[g_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (sq_we) begin
      sq_id_mem[s_wr_q]  <= in_q.caller_id;
      sq_val_mem[s_wr_q] <= in_q.set_value;
    end
    sq_id_rd_q  <= sq_id_mem[s_rd_q];
    sq_val_rd_q <= sq_val_mem[s_rd_q];
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

FILE: hdl/future_sync_mailbox.sv
// A get or set word is taken when start is high and busy is low, and its results follow
// one per strobe on result_valid_o, the final one marked by last; the receiver cannot stall,
// so every strobed word must be captured in its cycle. A word is registered in in_q and its
// first result in res_q before it is strobed, and the block can take its next word
// at the edge that ends the final strobe. An exclusive wakeup is sent from ST_XWAKE, a
// queue-mode wakeup from ST_GWAKE after ST_RWAIT and a setter admission from ST_ADMIT;
// a shared broadcast sends each woken getter from ST_BCAST, with ST_BWAIT between two
// of them while the next waiter queue entry is read through its registered memory port.
module future_sync_mailbox #(
  parameter int RING_DEPTH = 16,
  parameter int WAIT_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  fsmb_pkg::in_word_t           in_i,
  output logic                         result_valid_o,
  output fsmb_pkg::out_word_t          result_o,
  input  logic                         cfg_we_i,
  input  logic [fsmb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fsmb_pkg::CfgW-1:0]    cfg_data_i
);

  fsmb_pkg::dp_op_e     op;
  fsmb_pkg::dp_status_t status;

  fsmb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy)
  );

  fsmb_dpath #(
    .RING_DEPTH (RING_DEPTH),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .in_i           (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: hdl/fsmb_checker.sv
module fsmb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input fsmb_pkg::out_word_t result_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted word");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o)
    else $error("result strobed in the cycle after acceptance");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("result strobed right after a last result");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy)
    else $error("block idle while results are still owed");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.kind != fsmb_pkg::KIND_SERVED
      && result_o.kind != fsmb_pkg::KIND_GWOKEN) |-> (result_o.out_value == '0))
    else $error("nonzero value on a result that carries none");

endmodule

bind future_sync_mailbox fsmb_checker u_fsmb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
